[hw/rtl/divider_timer_peripheral_assert.svh]
// Assertion macros used by the divider timer peripheral back end.
`ifndef DIVIDER_TIMER_PERIPHERAL_ASSERT_SVH
`define DIVIDER_TIMER_PERIPHERAL_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dtp_pkg.sv]
// Types, constants and helper functions of the divider timer peripheral.
package dtp_pkg;

    localparam int FuncW  = 2;
    localparam int AddrW  = 16;
    localparam int DataW  = 8;
    localparam int DivW   = 14;
    localparam int DivRdLsb = 6;
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [AddrW-1:0] ADDR_DIV = 16'hFF04;
    localparam logic [AddrW-1:0] ADDR_CNT = 16'hFF05;
    localparam logic [AddrW-1:0] ADDR_MOD = 16'hFF06;
    localparam logic [AddrW-1:0] ADDR_CTL = 16'hFF07;

    localparam int CtlEnableBit = 2;

    localparam logic [FuncW-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FuncW-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FuncW-1:0] FUNC_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_READ,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        REG_DIV,
        REG_CNT,
        REG_MOD,
        REG_CTL
    } t_reg;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_OVF,
        PH_GUARD
    } t_phase;

    typedef struct packed {
        t_op              op;
        t_reg             sel;
        logic             bad;
        logic [DataW-1:0] wdata;
    } t_cmd;

    typedef struct packed {
        logic [DataW-1:0] rdata;
        logic             bad_address;
        logic             irq;
    } t_rsp;

    function automatic logic f_tap(input logic [DivW-1:0] div, input logic [1:0] freq);
        logic tap;
        case (freq)
            2'd0: tap = div[7];
            2'd1: tap = div[1];
            2'd2: tap = div[3];
            default: tap = div[5];
        endcase
        return tap;
    endfunction

endpackage

[hw/rtl/dtp_if.sv]
// Valid-ready channel interfaces for the request and response transactions.
interface dtp_req_if;
    logic                       valid;
    logic                       ready;
    logic [dtp_pkg::FuncW-1:0] func;
    logic [dtp_pkg::AddrW-1:0] addr;
    logic [dtp_pkg::DataW-1:0] wdata;

    modport source (output valid, output func, output addr, output wdata, input ready);
    modport sink (input valid, input func, input addr, input wdata, output ready);
endinterface

interface dtp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [dtp_pkg::DataW-1:0] rdata;
    logic                       bad_address;
    logic                       irq;

    modport source (output valid, output rdata, output bad_address, output irq, input ready);
    modport sink (input valid, input rdata, input bad_address, input irq, output ready);
endinterface

[hw/rtl/dtp_front.sv]
// Front end: accepts request transactions and decodes them into commands.
module dtp_front (
    dtp_req_if.sink         i_req,
    input  logic            i_full,
    output logic            o_push,
    output dtp_pkg::t_cmd   o_cmd
);
    import dtp_pkg::*;

    logic is_access;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_cmd.wdata = i_req.wdata;
        o_cmd.sel   = REG_DIV;
        o_cmd.bad   = 1'b0;
        case (i_req.func)
            FUNC_TICK:  o_cmd.op = OP_TICK;
            FUNC_WRITE: o_cmd.op = OP_WRITE;
            FUNC_READ:  o_cmd.op = OP_READ;
            default:    o_cmd.op = OP_NONE;
        endcase
        is_access = (o_cmd.op == OP_WRITE) || (o_cmd.op == OP_READ);
        case (i_req.addr)
            ADDR_DIV: o_cmd.sel = REG_DIV;
            ADDR_CNT: o_cmd.sel = REG_CNT;
            ADDR_MOD: o_cmd.sel = REG_MOD;
            ADDR_CTL: o_cmd.sel = REG_CTL;
            default:  o_cmd.bad = is_access;
        endcase
    end

endmodule

[hw/rtl/dtp_queue.sv]
// Two-entry command queue between the front end and the back end.
module dtp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtp_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dtp_pkg::t_cmd   o_cmd
);
    import dtp_pkg::*;

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic [QCntW-1:0] n_count;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPtrW'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPtrW'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/dtp_back.sv]
// Back end: timer state, command execution and the response register.
`include "divider_timer_peripheral_assert.svh"

module dtp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dtp_pkg::t_cmd   i_cmd,
    output logic            o_pop,
    dtp_rsp_if.source       o_rsp
);
    import dtp_pkg::*;

    logic [DivW-1:0]  r_div;
    logic [DataW-1:0] r_cnt;
    logic [DataW-1:0] r_mod;
    logic [DataW-1:0] r_ctl;
    logic             r_last_tap;
    t_phase           r_phase;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [DivW-1:0]  n_div;
    logic [DataW-1:0] n_cnt;
    logic [DataW-1:0] n_mod;
    logic [DataW-1:0] n_ctl;
    logic             n_last_tap;
    t_phase           n_phase;
    t_rsp             n_out;
    logic             fire;
    logic             is_tick;
    logic             cnt_wr;
    logic             inc;
    logic             tap;
    logic [DataW-1:0] cnt_inc;

    assign fire    = i_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop   = fire;
    assign is_tick = (i_cmd.op == OP_TICK);
    assign cnt_wr  = (i_cmd.op == OP_WRITE) && !i_cmd.bad && (i_cmd.sel == REG_CNT);
    assign tap     = f_tap(r_div + 1'b1, r_ctl[1:0]);
    assign inc     = is_tick && r_ctl[CtlEnableBit] && r_last_tap && !tap;
    assign cnt_inc = r_cnt + 1'b1;

    always_comb begin
        n_phase = r_phase;
        if (is_tick) begin
            case (r_phase)
                PH_OVF:   n_phase = PH_GUARD;
                PH_GUARD: n_phase = PH_COUNT;
                default:  n_phase = (inc && cnt_inc == '0) ? PH_OVF : PH_COUNT;
            endcase
        end else if (cnt_wr && r_phase == PH_OVF) begin
            n_phase = PH_COUNT;
        end
    end

    always_comb begin
        n_div      = r_div;
        n_cnt      = r_cnt;
        n_mod      = r_mod;
        n_ctl      = r_ctl;
        n_last_tap = r_last_tap;
        n_out      = '0;
        case (i_cmd.op)
            OP_TICK: begin
                n_div      = r_div + 1'b1;
                n_last_tap = tap;
                if (r_phase == PH_OVF) begin
                    n_cnt     = r_mod;
                    n_out.irq = 1'b1;
                end else if (r_phase != PH_GUARD && inc) begin
                    n_cnt = cnt_inc;
                end
            end
            OP_WRITE: begin
                n_out.bad_address = i_cmd.bad;
                if (!i_cmd.bad) begin
                    case (i_cmd.sel)
                        REG_DIV: n_div = '0;
                        REG_CNT: begin
                            if (r_phase != PH_GUARD) begin
                                n_cnt = i_cmd.wdata;
                            end
                        end
                        REG_MOD: n_mod = i_cmd.wdata;
                        default: n_ctl = i_cmd.wdata;
                    endcase
                end
            end
            OP_READ: begin
                n_out.bad_address = i_cmd.bad;
                if (!i_cmd.bad) begin
                    case (i_cmd.sel)
                        REG_DIV: n_out.rdata = r_div[DivRdLsb +: DataW];
                        REG_CNT: n_out.rdata = r_cnt;
                        REG_MOD: n_out.rdata = r_mod;
                        default: n_out.rdata = r_ctl;
                    endcase
                end
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div       <= '0;
            r_cnt       <= '0;
            r_mod       <= '0;
            r_ctl       <= '0;
            r_last_tap  <= 1'b0;
            r_phase     <= PH_COUNT;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_div      <= n_div;
                r_cnt      <= n_cnt;
                r_mod      <= n_mod;
                r_ctl      <= n_ctl;
                r_last_tap <= n_last_tap;
                r_phase    <= n_phase;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.rdata       = r_out.rdata;
    assign o_rsp.bad_address = r_out.bad_address;
    assign o_rsp.irq         = r_out.irq;

    `DTP_ASSERT_NEXT(a_ovf_to_guard, fire && is_tick && r_phase == PH_OVF, r_phase == PH_GUARD && r_out.irq, "Overflow tick did not reload and raise the interrupt.")
    `DTP_ASSERT_NEXT(a_guard_to_count, fire && is_tick && r_phase == PH_GUARD, r_phase == PH_COUNT, "Guard phase lasted more than one tick.")
    `DTP_ASSERT_NOW(a_irq_clean, r_out_valid && r_out.irq, r_out.rdata == '0 && !r_out.bad_address, "Interrupt response carries read data or an error.")
    `DTP_ASSERT_NEXT(a_stall_hold, r_out_valid && !o_rsp.ready, r_out_valid && $stable(r_out), "Stalled response changed before it was taken.")

endmodule

[hw/rtl/divider_timer_peripheral.sv]
// Top level of the divider timer peripheral.
// The block takes one request transaction per item on i_req: func 0 is a
// machine-cycle tick, func 1 a bus write and func 2 a bus read, with addr and
// wdata for the accesses. Every request yields exactly one response
// transaction on o_rsp with rdata, bad_address and irq.
// The front end decodes the request into a two-entry command queue, and the
// back end executes one command per cycle against the timer state and loads
// the response register while o_rsp.ready is high. A request is registered in
// the queue, and its response then in the response register; while o_rsp.ready
// stays high a new request can be accepted every cycle, one transaction per cycle.
// When the receiver holds o_rsp.ready low, the response register keeps its
// transaction, the back end stops, the queue fills, and i_req.ready falls
// once both queue entries are taken; nothing is dropped or repeated.
// Synchronous reset clears the divider, counter, modulo and control
// registers, puts the timer in its counting phase and empties the queue and
// the response register.
module divider_timer_peripheral (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtp_req_if.sink   i_req,
    dtp_rsp_if.source o_rsp
);
    import dtp_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic full;
    logic pop;
    logic queue_valid;

    dtp_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    dtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    dtp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
